### hw/rtl/pls_pkg.sv
`default_nettype none

package pls_pkg;

    // default build constants
    localparam int ROUND_LINES_DEF   = 180;
    localparam int LINE_LEDS_DEF     = 26;
    localparam int AVERAGE_COUNT_DEF = 32;

    // fixed field widths
    localparam int CAP_W      = 16;
    localparam int PERIOD_W   = 16;
    localparam int ZERO_W     = 8;
    localparam int BYTES_W    = 7;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_PTR    = 3;

    // register reset values
    localparam logic [ZERO_W-1:0]   ZERO_LINE_RST  = 8'd95;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = 16'd3500;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = 16'd65000;

    // transfer sizes of the markers
    localparam logic [BYTES_W-1:0] START_BYTES = 7'd4;
    localparam logic [BYTES_W-1:0] END_BYTES   = 7'd5;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_DONE = 2'd1,
        KIND_HALL = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ACT_START  = 3'd0,
        ACT_LINE   = 3'd1,
        ACT_END    = 3'd2,
        ACT_RELOAD = 3'd3,
        ACT_FAULT  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        PHASE_LINES = 2'd0,
        PHASE_END   = 2'd1,
        PHASE_CLOSE = 2'd2
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_LINE  = 2'd0,
        CFG_MIN_PERIOD = 2'd1,
        CFG_MAX_PERIOD = 2'd2
    } cfg_index_t;

    // control carried by the input register
    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  avg_due;
    } stage_t;

    // result of the frame sequencer
    typedef struct packed {
        logic               hit;
        action_t            action;
        logic [BYTES_W-1:0] bytes;
    } frame_res_t;

    // result of the period check
    typedef struct packed {
        logic                hit;
        action_t             action;
        logic [PERIOD_W-1:0] reload;
    } period_res_t;

endpackage

`default_nettype wire

### hw/rtl/pls_capture_acc.sv
`default_nettype none

module pls_capture_acc
    import pls_pkg::*;
#(
    parameter int AVERAGE_COUNT = AVERAGE_COUNT_DEF,
    parameter int SUM_W         = $clog2(AVERAGE_COUNT) + CAP_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic             adv,
    input  wire logic [1:0]       kind,
    input  wire logic [CAP_W-1:0] captured_period,
    output stage_t                stage,
    output logic [SUM_W-1:0]      sum_total
);

    localparam int CNT_W = (AVERAGE_COUNT > 1) ? $clog2(AVERAGE_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVERAGE_COUNT - 1);

    stage_t           stage_reg, stage_next;
    logic [SUM_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] sum_add;
    logic             due;

    // accumulate captures as they enter, so the divide sees a ready total
    always_comb begin
        sum_add    = sum_reg + SUM_W'(captured_period);
        due        = (count_reg == CNT_LAST);
        stage_next = stage_reg;
        total_next = total_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        if (adv) begin
            stage_next.valid = 1'b0;
        end
        if (accept) begin
            stage_next.valid   = 1'b1;
            stage_next.kind    = kind_t'(kind);
            stage_next.avg_due = 1'b0;
            total_next         = sum_add;
            if (kind_t'(kind) == KIND_HALL) begin
                stage_next.avg_due = due;
                if (due) begin
                    count_next = '0;
                    sum_next   = '0;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    sum_next   = sum_add;
                end
            end
        end
    end

    // input register and accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end else begin
            stage_reg <= stage_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= total_next;
    end

    assign stage     = stage_reg;
    assign sum_total = total_reg;

endmodule

`default_nettype wire

### hw/rtl/pls_frame_seq.sv
`default_nettype none

module pls_frame_seq
    import pls_pkg::*;
#(
    parameter int ROUND_LINES = ROUND_LINES_DEF,
    parameter int LINE_LEDS   = LINE_LEDS_DEF,
    parameter int LED_W       = $clog2(ROUND_LINES * LINE_LEDS)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire stage_t            stage,
    input  wire logic [ZERO_W-1:0] zero_line_offset,
    output frame_res_t             res,
    output logic [LED_W-1:0]       start_led
);

    localparam int BUF_SIZE   = ROUND_LINES * LINE_LEDS;
    localparam int THIRD_DIFF = (ROUND_LINES / 3) * LINE_LEDS;
    localparam int OFF0       = ((2 * THIRD_DIFF) % BUF_SIZE + BUF_SIZE - LINE_LEDS)
                                % BUF_SIZE;
    localparam int OFF1       = (THIRD_DIFF % BUF_SIZE + BUF_SIZE - LINE_LEDS) % BUF_SIZE;
    localparam int LINE_BYTES = (4 * LINE_LEDS) % (1 << BYTES_W);
    localparam int ZERO_DEPTH = 1 << ZERO_W;

    localparam logic [LED_W-1:0] PTR0_RST = LED_W'((2 * THIRD_DIFF) % BUF_SIZE);
    localparam logic [LED_W-1:0] PTR1_RST = LED_W'(THIRD_DIFF % BUF_SIZE);
    localparam logic [LED_W:0]   BUF_EXT  = (LED_W + 1)'(BUF_SIZE);
    localparam logic [LED_W:0]   LEDS_EXT = (LED_W + 1)'(LINE_LEDS);

    phase_t           phase_reg, phase_next;
    logic             busy_reg, busy_next;
    logic [1:0]       slot_reg, slot_next;
    logic             resync_reg, resync_next;
    logic [LED_W-1:0] ptr_reg [NUM_PTR];
    logic [LED_W-1:0] ptr_next [NUM_PTR];
    logic [LED_W-1:0] resync_tab [ZERO_DEPTH];
    logic [1:0]       slot;
    logic [LED_W:0]   sync0, sync1, step;
    logic [LED_W-1:0] sync2;

    // resync line for every zero offset, worked out at elaboration
    for (genvar g = 0; g < ZERO_DEPTH; g++) begin : g_tab
        localparam int P2 = (LINE_LEDS * g + BUF_SIZE - LINE_LEDS) % BUF_SIZE;
        assign resync_tab[g] = LED_W'(P2);
    end

    // frame sequence and pointer update
    always_comb begin
        phase_next  = phase_reg;
        busy_next   = busy_reg;
        slot_next   = slot_reg;
        resync_next = resync_reg;
        ptr_next    = ptr_reg;
        res         = '0;
        start_led   = '0;
        step        = '0;
        slot        = (slot_reg < 2'd3) ? slot_reg : 2'd2;
        sync2       = resync_tab[zero_line_offset];
        sync0       = {1'b0, sync2} + (LED_W + 1)'(OFF0);
        sync1       = {1'b0, sync2} + (LED_W + 1)'(OFF1);
        if (sync0 >= BUF_EXT) begin
            sync0 = sync0 - BUF_EXT;
        end
        if (sync1 >= BUF_EXT) begin
            sync1 = sync1 - BUF_EXT;
        end
        if (adv && stage.valid) begin
            case (stage.kind)
                KIND_TICK: begin
                    if (!busy_reg) begin
                        busy_next  = 1'b1;
                        res.hit    = 1'b1;
                        res.action = ACT_START;
                        res.bytes  = START_BYTES;
                        if (resync_reg) begin
                            ptr_next[0] = sync0[LED_W-1:0];
                            ptr_next[1] = sync1[LED_W-1:0];
                            ptr_next[2] = sync2;
                            resync_next = 1'b0;
                        end
                    end
                end
                KIND_DONE: begin
                    case (phase_reg)
                        PHASE_LINES: begin
                            res.hit    = 1'b1;
                            res.action = ACT_LINE;
                            res.bytes  = BYTES_W'(LINE_BYTES);
                            start_led  = ptr_reg[slot];
                            slot_next  = slot + 2'd1;
                            if (slot == 2'd2) begin
                                phase_next = PHASE_END;
                            end
                        end
                        PHASE_END: begin
                            res.hit    = 1'b1;
                            res.action = ACT_END;
                            res.bytes  = END_BYTES;
                            phase_next = PHASE_CLOSE;
                        end
                        default: begin
                            // frame close: advance each pointer one line
                            phase_next = PHASE_LINES;
                            slot_next  = 2'd0;
                            busy_next  = 1'b0;
                            for (int i = 0; i < NUM_PTR; i++) begin
                                step = {1'b0, ptr_reg[i]} + LEDS_EXT;
                                if (step >= BUF_EXT) begin
                                    step = step - BUF_EXT;
                                end
                                ptr_next[i] = step[LED_W-1:0];
                            end
                        end
                    endcase
                end
                KIND_HALL: begin
                    resync_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PHASE_LINES;
            busy_reg   <= 1'b0;
            slot_reg   <= 2'd0;
            resync_reg <= 1'b0;
            ptr_reg[0] <= PTR0_RST;
            ptr_reg[1] <= PTR1_RST;
            ptr_reg[2] <= '0;
        end else begin
            phase_reg  <= phase_next;
            busy_reg   <= busy_next;
            slot_reg   <= slot_next;
            resync_reg <= resync_next;
            ptr_reg    <= ptr_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pls_period_check.sv
`default_nettype none

module pls_period_check
    import pls_pkg::*;
#(
    parameter int ROUND_LINES   = ROUND_LINES_DEF,
    parameter int AVERAGE_COUNT = AVERAGE_COUNT_DEF,
    parameter int SUM_W         = $clog2(AVERAGE_COUNT) + CAP_W
) (
    input  wire stage_t                stage,
    input  wire logic                  adv,
    input  wire logic [SUM_W-1:0]      sum_total,
    input  wire logic [PERIOD_W-1:0]   min_line_period,
    input  wire logic [PERIOD_W-1:0]   max_line_period,
    output period_res_t                res
);

    // exact divide by the line count through a rounded-up reciprocal
    localparam int          SHIFT = SUM_W + $clog2(ROUND_LINES);
    localparam int          MUL_W = SUM_W + 1;
    localparam int          Q_W   = SUM_W + MUL_W - SHIFT;
    localparam int          CMP_W = (Q_W > PERIOD_W) ? Q_W : PERIOD_W;
    localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(ROUND_LINES) - 64'd1)
                                    / 64'(ROUND_LINES);

    logic [SUM_W+MUL_W-1:0] product;
    logic [Q_W-1:0]         avg;
    logic [CMP_W-1:0]       avg_ext;
    logic                   in_range;

    assign product  = sum_total * RECIP[MUL_W-1:0];
    assign avg      = product[SHIFT +: Q_W];
    assign avg_ext  = CMP_W'(avg);
    assign in_range = (avg_ext > CMP_W'(min_line_period))
                   && (avg_ext < CMP_W'(max_line_period));

    // reload or fault once a full set of captures is in
    always_comb begin
        res = '0;
        if (adv && stage.valid && stage.kind == KIND_HALL && stage.avg_due) begin
            res.hit = 1'b1;
            if (in_range) begin
                res.action = ACT_RELOAD;
                res.reload = PERIOD_W'(avg_ext - CMP_W'(2));
            end else begin
                res.action = ACT_FAULT;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pov_line_scheduler.sv
// a result beat passes the input register and then the single output register
// throughput: one event per cycle while the output register is empty or being taken
// events that give no result still pass the input register
// reset: synchronous active-low aresetn returns pointers, counters and registers
// to their defaults at once (data registers excepted); there is no clearing pass
`default_nettype none

module pov_line_scheduler
    import pls_pkg::*;
#(
    parameter int ROUND_LINES   = ROUND_LINES_DEF,
    parameter int LINE_LEDS     = LINE_LEDS_DEF,
    parameter int AVERAGE_COUNT = AVERAGE_COUNT_DEF,
    parameter int LED_W         = $clog2(ROUND_LINES * LINE_LEDS)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_kind,
    input  wire logic [CAP_W-1:0]      s_captured_period,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_action,
    output logic [LED_W-1:0]           m_start_led,
    output logic [BYTES_W-1:0]         m_byte_count,
    output logic [PERIOD_W-1:0]        m_reload_value
);

    localparam int SUM_W = $clog2(AVERAGE_COUNT) + CAP_W;

    logic [ZERO_W-1:0]   zero_reg;
    logic [PERIOD_W-1:0] min_reg;
    logic [PERIOD_W-1:0] max_reg;

    stage_t              stage;
    logic [SUM_W-1:0]    sum_total;
    frame_res_t          fres;
    period_res_t         pres;
    logic [LED_W-1:0]    led;

    logic                out_free, adv, accept;
    logic                m_valid_reg, m_valid_next;
    action_t             action_reg, action_next;
    logic [LED_W-1:0]    led_reg, led_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [PERIOD_W-1:0] reload_reg, reload_next;

    // handshake: the input register moves on whenever the output register is free
    assign out_free = !m_valid_reg || m_ready;
    assign adv      = stage.valid && out_free;
    assign s_ready  = !stage.valid || out_free;
    assign accept   = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_reg <= ZERO_LINE_RST;
            min_reg  <= MIN_PERIOD_RST;
            max_reg  <= MAX_PERIOD_RST;
        end else if (cfg_wen) begin
            case (cfg_index_t'(cfg_index))
                CFG_ZERO_LINE:  zero_reg <= cfg_wdata[ZERO_W-1:0];
                CFG_MIN_PERIOD: min_reg  <= cfg_wdata[PERIOD_W-1:0];
                CFG_MAX_PERIOD: max_reg  <= cfg_wdata[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pls_capture_acc #(
        .AVERAGE_COUNT (AVERAGE_COUNT),
        .SUM_W         (SUM_W)
    ) u_acc (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .adv             (adv),
        .kind            (s_kind),
        .captured_period (s_captured_period),
        .stage           (stage),
        .sum_total       (sum_total)
    );

    pls_frame_seq #(
        .ROUND_LINES (ROUND_LINES),
        .LINE_LEDS   (LINE_LEDS),
        .LED_W       (LED_W)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .adv              (adv),
        .stage            (stage),
        .zero_line_offset (zero_reg),
        .res              (fres),
        .start_led        (led)
    );

    pls_period_check #(
        .ROUND_LINES   (ROUND_LINES),
        .AVERAGE_COUNT (AVERAGE_COUNT),
        .SUM_W         (SUM_W)
    ) u_chk_period (
        .stage           (stage),
        .adv             (adv),
        .sum_total       (sum_total),
        .min_line_period (min_reg),
        .max_line_period (max_reg),
        .res             (pres)
    );

    // output register: merge whichever unit has a result
    always_comb begin
        m_valid_next = m_valid_reg;
        action_next  = action_reg;
        led_next     = led_reg;
        bytes_next   = bytes_reg;
        reload_next  = reload_reg;
        if (out_free) begin
            m_valid_next = adv && (fres.hit || pres.hit);
        end
        if (adv) begin
            action_next = fres.hit ? fres.action : pres.action;
            led_next    = led;
            bytes_next  = fres.hit ? fres.bytes : '0;
            reload_next = pres.hit ? pres.reload : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        led_reg    <= led_next;
        bytes_reg  <= bytes_next;
        reload_reg <= reload_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_action       = action_reg;
    assign m_start_led    = led_reg;
    assign m_byte_count   = bytes_reg;
    assign m_reload_value = reload_reg;

endmodule

`default_nettype wire

### hw/rtl/pls_checker.sv
`default_nettype none

module pls_checker
    import pls_pkg::*;
#(
    parameter int LED_W = 13
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [2:0]          m_action,
    input wire logic [LED_W-1:0]    m_start_led,
    input wire logic [BYTES_W-1:0]  m_byte_count,
    input wire logic [PERIOD_W-1:0] m_reload_value
);

    // no result beat survives a reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an empty output register never holds back the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // markers carry their fixed sizes and no line address
    a_marker_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == ACT_START || m_action == ACT_END)
        |-> m_start_led == '0 && m_reload_value == '0
            && (m_byte_count == START_BYTES || m_byte_count == END_BYTES))
        else $error("marker beat with stray fields");

    // period beats carry no transfer
    a_period_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == ACT_RELOAD || m_action == ACT_FAULT)
        |-> m_byte_count == '0 && m_start_led == '0)
        else $error("period beat with transfer fields");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_action) && $stable(m_start_led)
            && $stable(m_byte_count) && $stable(m_reload_value))
        else $error("stalled result beat changed");

endmodule

bind pov_line_scheduler pls_checker #(
    .LED_W (LED_W)
) u_pls_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_action       (m_action),
    .m_start_led    (m_start_led),
    .m_byte_count   (m_byte_count),
    .m_reload_value (m_reload_value)
);

`default_nettype wire
